// ===== rtl/core/gif_lzw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_pkg
// Shared types and constants of the GIF LZW code stream encoder.
// -----------------------------------------------------------------------------
package gif_lzw_pkg;

	localparam int SYM_BITS   = 8;
	localparam int EPOCH_BITS = 8;

	localparam logic [3:0] MCS_MIN   = 4'd2;
	localparam logic [3:0] MCS_MAX   = 4'd8;
	localparam logic [3:0] MCS_RESET = 4'd8;

	// register index, taken from paddr[2]
	localparam logic REG_CODE_SIZE = 1'b0;

	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	typedef struct packed {
		logic [SYM_BITS-1:0] sym;
		logic                last;
	} pix_item_t;

	typedef struct packed {
		logic [3:0] mcs;    // clamped min code size
		logic       clear;  // config write: abandon the image
	} cfg_ctl_t;

	function automatic logic [3:0] eff_mcs(input logic [3:0] raw);
		if (raw < MCS_MIN) begin
			return MCS_MIN;
		end else if (raw > MCS_MAX) begin
			return MCS_MAX;
		end
		return raw;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gif_lzw_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_pix_if
// Pixel request channel: palette index and last flag.
// -----------------------------------------------------------------------------
interface gif_lzw_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_index;
	logic       last_pixel;

	modport source (output valid, output pixel_index, output last_pixel, input ready);
	modport sink   (input valid, input pixel_index, input last_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gif_lzw_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_byte_if
// Byte request channel: packed code stream byte and last flag.
// -----------------------------------------------------------------------------
interface gif_lzw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gif_lzw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_ram
// Generic simple dual port RAM, one write port, registered read.
// -----------------------------------------------------------------------------
module gif_lzw_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/gif_lzw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_front
// Accepts pixels, masks them to the code size and queues them (two deep).
// -----------------------------------------------------------------------------
module gif_lzw_front import gif_lzw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        mcs,
	input  logic              hold,
	gif_lzw_pix_if.sink       pix,
	output logic              q_valid,
	output pix_item_t         q_item,
	input  logic              q_pop
);
	pix_item_t  slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic [8:0] mask;
	logic       push;

	assign mask      = (9'd1 << mcs) - 9'd1;
	assign pix.ready = (cnt_q != 2'd2) && !hold;
	assign push      = pix.valid && pix.ready;
	assign q_valid   = cnt_q != 2'd0;
	assign q_item    = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				slot_q[wr_q].sym  <= pix.pixel_index & mask[7:0];
				slot_q[wr_q].last <= pix.last_pixel;
				wr_q              <= !wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gif_lzw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_back
// Dictionary lookup and insert, code sequencing and LSB-first byte packing.
// -----------------------------------------------------------------------------
module gif_lzw_back import gif_lzw_pkg::*; #(
	parameter int MAX_CODE_BITS = 12,
	parameter int DICT_SLOTS    = 8192
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_ctl_t      cfg,
	input  logic          q_valid,
	input  pix_item_t     q_item,
	output logic          q_pop,
	output logic          sweeping,
	gif_lzw_byte_if.source bytes
);
	localparam int SLOT_BITS = $clog2(DICT_SLOTS);
	localparam int KEY_BITS  = MAX_CODE_BITS + SYM_BITS;
	localparam int ENTRY_W   = 1 + EPOCH_BITS + KEY_BITS + MAX_CODE_BITS;
	localparam int ACC_W     = MAX_CODE_BITS + 7;
	localparam int CNT_W     = $clog2(ACC_W + 1);
	localparam int NFC_W     = MAX_CODE_BITS + 1;
	localparam logic [NFC_W-1:0] LAST_FREE = NFC_W'((1 << MAX_CODE_BITS) - 1);

	typedef struct packed {
		logic                     live;
		logic [EPOCH_BITS-1:0]    epoch;
		logic [KEY_BITS-1:0]      key;
		logic [MAX_CODE_BITS-1:0] code;
	} entry_t;

	typedef enum logic [2:0] {
		ST_SWEEP, ST_IDLE, ST_CMP, ST_MISS, ST_CLR, ST_CLR2, ST_LP, ST_LE
	} state_t;

	state_t                   state_q, ret_q, after;
	logic [SLOT_BITS-1:0]     sweep_q, probe_q, hash_head, rd_addr, wr_addr;
	logic [EPOCH_BITS-1:0]    epoch_q;
	logic [MAX_CODE_BITS-1:0] prefix_q, clr_code, eoi_code, put_code;
	logic [NFC_W-1:0]         nfc_q, nfc_restart;
	logic [3:0]               width_q;
	logic [SYM_BITS-1:0]      sym_q;
	logic                     last_q, started_q;
	logic [KEY_BITS-1:0]      key_head, key_q;
	logic [ENTRY_W-1:0]       rd_data;
	entry_t                   rd_e, wr_e;
	logic                     live, hit, we;
	logic [ACC_W-1:0]         acc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     final_q, room, put_en, emit, emit_last;
	logic                     ov_q, ol_q;
	logic [7:0]               od_q;

	assign clr_code    = MAX_CODE_BITS'(1) << cfg.mcs;
	assign eoi_code    = clr_code | MAX_CODE_BITS'(1);
	assign nfc_restart = NFC_W'(clr_code) + NFC_W'(2);
	assign key_head    = {prefix_q, q_item.sym};
	assign key_q       = {prefix_q, sym_q};
	assign hash_head   = key_head[SLOT_BITS-1:0] * HASH_MULT[SLOT_BITS-1:0];
	assign rd_addr     = (state_q == ST_IDLE) ? hash_head : probe_q + 1'b1;
	assign rd_e        = entry_t'(rd_data);
	assign live        = rd_e.live && (rd_e.epoch == epoch_q);
	assign hit         = live && (rd_e.key == key_q);
	assign after       = last_q ? ST_LP : ST_IDLE;
	assign q_pop       = (state_q == ST_IDLE) && q_valid;
	assign sweeping    = state_q == ST_SWEEP;

	assign room = (cnt_q < CNT_W'(8)) && !final_q;

	always_comb begin
		put_code = prefix_q;
		put_en   = 1'b0;
		unique case (state_q)
			ST_CLR, ST_CLR2: begin
				put_code = clr_code;
				put_en   = room;
			end
			ST_MISS, ST_LP: begin
				put_en = room;
			end
			ST_LE: begin
				put_code = eoi_code;
				put_en   = room;
			end
			default: begin
				put_en = 1'b0;
			end
		endcase
	end

	assign we      = sweeping || ((state_q == ST_MISS) && room);
	assign wr_addr = sweeping ? sweep_q : probe_q;
	always_comb begin
		wr_e       = '0;
		if (!sweeping) begin
			wr_e.live  = 1'b1;
			wr_e.epoch = epoch_q;
			wr_e.key   = key_q;
			wr_e.code  = nfc_q[MAX_CODE_BITS-1:0];
		end
	end

	gif_lzw_ram #(.WIDTH(ENTRY_W), .DEPTH(DICT_SLOTS)) u_dict (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wr_e),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign emit      = ((cnt_q >= CNT_W'(8)) || (final_q && (cnt_q != '0)))
		&& (!ov_q || bytes.ready);
	assign emit_last = final_q && (cnt_q <= CNT_W'(8));

	assign bytes.valid     = ov_q;
	assign bytes.data_byte = od_q;
	assign bytes.last_byte = ol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			ret_q     <= ST_IDLE;
			sweep_q   <= '0;
			probe_q   <= '0;
			epoch_q   <= '0;
			prefix_q  <= '0;
			nfc_q     <= '0;
			width_q   <= '0;
			sym_q     <= '0;
			last_q    <= 1'b0;
			started_q <= 1'b0;
			acc_q     <= '0;
			cnt_q     <= '0;
			final_q   <= 1'b0;
			ov_q      <= 1'b0;
			ol_q      <= 1'b0;
			od_q      <= '0;
		end else begin
			// byte packer
			if (emit) begin
				od_q  <= acc_q[7:0];
				ol_q  <= emit_last;
				ov_q  <= 1'b1;
				acc_q <= acc_q >> 8;
				cnt_q <= (cnt_q >= CNT_W'(8)) ? cnt_q - CNT_W'(8) : '0;
				if (emit_last) begin
					final_q <= 1'b0;
				end
			end else if (bytes.ready) begin
				ov_q <= 1'b0;
			end
			if (put_en) begin
				acc_q <= acc_q | (ACC_W'(put_code) << cnt_q);
				cnt_q <= cnt_q + CNT_W'(width_q);
				if (state_q == ST_LE) begin
					final_q <= 1'b1;
				end
			end

			// sequencer
			unique case (state_q)
				ST_SWEEP: begin
					if (&sweep_q) begin
						sweep_q <= '0;
						state_q <= ret_q;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						sym_q  <= q_item.sym;
						last_q <= q_item.last;
						if (!started_q) begin
							nfc_q   <= nfc_restart;
							width_q <= cfg.mcs + 4'd1;
							epoch_q <= epoch_q + 1'b1;
							ret_q   <= ST_CLR;
							state_q <= (&epoch_q) ? ST_SWEEP : ST_CLR;
						end else begin
							probe_q <= hash_head;
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (!live) begin
						state_q <= ST_MISS;
					end else if (hit) begin
						prefix_q <= rd_e.code;
						state_q  <= after;
					end else begin
						probe_q <= probe_q + 1'b1;
					end
				end
				ST_MISS: begin
					if (room) begin
						if ((width_q < 4'(MAX_CODE_BITS)) && (nfc_q == (NFC_W'(1) << width_q)))
						begin
							width_q <= width_q + 4'd1;
						end
						nfc_q <= nfc_q + 1'b1;
						if (nfc_q == LAST_FREE) begin
							state_q <= ST_CLR2;
						end else begin
							prefix_q <= MAX_CODE_BITS'(sym_q);
							state_q  <= after;
						end
					end
				end
				ST_CLR: begin
					if (room) begin
						prefix_q  <= MAX_CODE_BITS'(sym_q);
						started_q <= 1'b1;
						state_q   <= after;
					end
				end
				ST_CLR2: begin
					if (room) begin
						nfc_q    <= nfc_restart;
						width_q  <= cfg.mcs + 4'd1;
						epoch_q  <= epoch_q + 1'b1;
						prefix_q <= MAX_CODE_BITS'(sym_q);
						ret_q    <= after;
						state_q  <= (&epoch_q) ? ST_SWEEP : after;
					end
				end
				ST_LP: begin
					if (room) begin
						state_q <= ST_LE;
					end
				end
				ST_LE: begin
					if (room) begin
						started_q <= 1'b0;
						prefix_q  <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg.clear) begin
				started_q <= 1'b0;
				acc_q     <= '0;
				cnt_q     <= '0;
				final_q   <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gif_lzw_code_stream_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gif_lzw_code_stream_encoder
// GIF LZW encoder: palette indices in, LSB-first packed code stream bytes out.
// -----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  pix      in   valid/ready             pixel_index[7:0], last_pixel
//  bytes    out  valid/ready             data_byte[7:0], last_byte
//  apb      in   psel/penable, pready=1  code size register at 0x0
//
// Hit: hash and RAM read, compare; each extra probe compares again. A miss
// then puts the prefix and writes the entry; a table restart puts the clear
// code; the first pixel of an image puts it too, the last prefix and end code.
// Reset starts a RAM sweep of all DICT_SLOTS entries with pix.ready low;
// it reruns on every 256th table restart when the epoch tag wraps. Codes wait
// while the packer holds 8 or more bits; a stalled byte output holds it.
// -----------------------------------------------------------------------------
module gif_lzw_code_stream_encoder import gif_lzw_pkg::*; #(
	parameter int MAX_CODE_BITS = 12,
	parameter int DICT_SLOTS    = 8192
) (
	input  logic         clk,
	input  logic         arst_n,
	gif_lzw_pix_if.sink  pix,
	gif_lzw_byte_if.source bytes,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [3:0] mcs_q;
	logic       reg_hit;
	logic       cfg_wr;
	cfg_ctl_t   cfg;
	logic       q_valid, q_pop, sweeping;
	pix_item_t  q_item;

	// register file: one 4-bit register, word aligned
	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == REG_CODE_SIZE;
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? {28'd0, mcs_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcs_q <= MCS_RESET;
		end else if (cfg_wr) begin
			mcs_q <= pwdata[3:0];
		end
	end

	// a write abandons the current image and drops pending bits
	assign cfg.mcs   = eff_mcs(mcs_q);
	assign cfg.clear = cfg_wr;

	gif_lzw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.mcs     (cfg.mcs),
		.hold    (sweeping),
		.pix     (pix),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	gif_lzw_back #(
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.DICT_SLOTS    (DICT_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.sweeping (sweeping),
		.bytes    (bytes)
	);
endmodule
`default_nettype wire

// ===== tb/gif_lzw_code_stream_encoder_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gif_lzw_code_stream_encoder_tb
// Self-checking bench: pixel images go in, the packed code stream bytes are
// compared with a behavioral LZW encoder kept in step with the block.
// -----------------------------------------------------------------------------
module gif_lzw_code_stream_encoder_tb;
	import gif_lzw_pkg::*;

	localparam int DICT_N    = 8192;
	localparam int CODE_MAX  = 4096;
	localparam int CYC_LIMIT = 2_000_000;

	typedef struct {
		logic [7:0] pix;
		logic       last;
		logic       chk;    // typed-in expectation below is valid
		logic [7:0] b0;     // expected first byte
	} stim_row_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} code_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	gif_lzw_pix_if  pix ();
	gif_lzw_byte_if bytes ();

	gif_lzw_code_stream_encoder u_top (
		.clk(clk), .arst_n(arst_n), .pix(pix.sink), .bytes(bytes.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// ---------------- encoder state mirror ----------------
	logic        dict_vld [DICT_N];
	logic [19:0] dict_key [DICT_N];
	logic [11:0] dict_code[DICT_N];
	logic [3:0]  mcs_reg;
	logic [11:0] prefix;
	int unsigned nxt_code, code_w, acc_bits, acc_cnt;
	bit          in_image;
	logic [7:0]  step_b0;           // first byte released by the latest pixel

	code_byte_t  byte_q[$];
	int          err_cnt = 0;
	int          bytes_seen = 0, pix_sent = 0, images_done = 0;
	longint      cyc = 0;
	bit          hold_rx = 1'b0;    // long receiver hold-off in progress
	bit          rx_noise = 1'b1;

	function automatic int unsigned mcs_eff();
		return (mcs_reg < MCS_MIN) ? MCS_MIN : (mcs_reg > MCS_MAX) ? MCS_MAX : mcs_reg;
	endfunction

	function automatic void table_restart();
		foreach (dict_vld[i]) dict_vld[i] = 1'b0;
		nxt_code = (1 << mcs_eff()) + 2;
		code_w = mcs_eff() + 1;
	endfunction

	function automatic void image_abandon();
		table_restart();
		prefix = '0;
		acc_bits = 0;
		acc_cnt = 0;
		in_image = 1'b0;
	endfunction

	function automatic void emit_code(int unsigned code, int unsigned w);
		int unsigned acc, cnt;
		code_byte_t  b;
		acc = acc_bits | ((code & 12'hfff) << acc_cnt);
		cnt = acc_cnt + w;
		while (cnt >= 8) begin
			b.data = acc[7:0];
			b.last = 1'b0;
			byte_q.insert(byte_q.size(), b);
			acc >>= 8;
			cnt -= 8;
		end
		acc_bits = acc & 7'h7f;
		acc_cnt = cnt;
	endfunction

	// Encodes one pixel and queues the bytes it releases.
	function automatic void encode_pixel(logic [7:0] raw, logic last);
		int unsigned clr, sym, slot, n;
		logic [19:0] key;
		logic [31:0] h;
		bit hit, found_free;
		code_byte_t b;
		int unsigned q0;
		q0 = byte_q.size();
		clr = 1 << mcs_eff();
		sym = raw & (clr - 1);
		if (!in_image) begin
			table_restart();
			acc_bits = 0;
			acc_cnt = 0;
			emit_code(clr, code_w);
			prefix = 12'(sym);
			in_image = 1'b1;
		end else begin
			key = {prefix, sym[7:0]};
			h = 32'(key) * HASH_MULT;
			slot = h % DICT_N;
			hit = 1'b0;
			found_free = 1'b0;
			for (n = 0; n < DICT_N; n++) begin
				if (!dict_vld[slot]) begin
					found_free = 1'b1;
					break;
				end
				if (dict_key[slot] == key) begin
					hit = 1'b1;
					break;
				end
				slot = (slot + 1) % DICT_N;
			end
			if (hit) begin
				prefix = dict_code[slot];
			end else begin
				emit_code(prefix, code_w);
				if (found_free) begin
					dict_vld[slot] = 1'b1;
					dict_key[slot] = key;
					dict_code[slot] = nxt_code[11:0];
				end
				if (code_w < 12 && nxt_code == (1 << code_w))
					code_w++;
				nxt_code++;
				if (nxt_code >= CODE_MAX) begin
					emit_code(clr, code_w);
					table_restart();
				end
				prefix = 12'(sym);
			end
		end
		if (last) begin
			emit_code(prefix, code_w);
			emit_code(clr + 1, code_w);
			if (acc_cnt > 0) begin
				b.data = acc_bits[7:0];
				b.last = 1'b0;
				byte_q.insert(byte_q.size(), b);
			end
			if (byte_q.size() > q0) byte_q[$].last = 1'b1;
			image_abandon();
			images_done++;
		end
		step_b0 = (byte_q.size() > q0) ? byte_q[q0].data : 8'h00;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h want %0h (byte %0d)", what, got, want, bytes_seen);
		err_cnt++;
	endtask

	// ---------------- byte sink / checker ----------------
	always @(posedge clk) begin
		code_byte_t w;
		cyc <= cyc + 1;
		if (bytes.valid && bytes.ready) begin
			if (byte_q.size() == 0) begin
				report_mismatch("unexpected byte", bytes.data_byte, 0);
			end else begin
				w = byte_q.pop_front();
				if (bytes.data_byte !== w.data)
					report_mismatch("data_byte", bytes.data_byte, w.data);
				if (bytes.last_byte !== w.last)
					report_mismatch("last_byte", bytes.last_byte, w.last);
			end
			bytes_seen <= bytes_seen + 1;
		end
	end

	// Receiver stall pattern: mostly short gaps, some long, long hold-off on demand.
	initial begin
		int gap;
		bytes.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				bytes.ready <= 1'b0;
			end else if (!rx_noise || $urandom_range(0, 3) != 0) begin
				bytes.ready <= 1'b1;
			end else begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				bytes.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	// Timeout watchdog.
	initial begin
		wait (cyc >= CYC_LIMIT);
		$display("timeout after %0d cycles, %0d bytes pending", cyc, byte_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- drivers ----------------
	task automatic apb_write(logic [3:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_CODE_SIZE, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		mcs_reg = val;
		image_abandon();
	endtask

	task automatic apb_read_check(logic [3:0] want);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b0; paddr <= {REG_CODE_SIZE, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[3:0] !== want) report_mismatch("prdata", prdata[3:0], want);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	// Offers one pixel, idles at random afterwards; the model runs at acceptance.
	task automatic send_pixel(logic [7:0] p, logic last, bit no_gap = 0);
		pix.valid <= 1'b1;
		pix.pixel_index <= p;
		pix.last_pixel <= last;
		do @(posedge clk); while (!pix.ready);
		encode_pixel(p, last);
		pix_sent++;
		@(negedge clk);
		if (!no_gap && $urandom_range(0, 3) == 0) begin
			pix.valid <= 1'b0;
			pix.pixel_index <= 8'($urandom);
			repeat (($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
				: $urandom_range(1, 2)) @(negedge clk);
		end
	endtask

	// Idle point before a register write: stop offering, drain, let the pipe settle.
	task automatic drain();
		pix.valid <= 1'b0;
		while (byte_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Random pixel from a small alphabet so that strings repeat and codes grow.
	function automatic logic [7:0] rand_pixel(int unsigned alpha);
		if ($urandom_range(0, 19) == 0) return 8'($urandom);   // unmasked noise
		return 8'($urandom_range(0, alpha - 1));
	endfunction

	task automatic send_image(int unsigned len, int unsigned alpha);
		for (int unsigned k = 0; k < len; k++)
			send_pixel(rand_pixel(alpha), k == len - 1);
	endtask

	// Directed rows (code size at reset value 8 unless noted in the loop).
	// A single 0 pixel at size 8 gives clear 0x100 then 0, end 0x101:
	// first byte is the low byte of the clear code.
	stim_row_t dir_tab[] = '{
		'{8'h00, 1'b1, 1'b1, 8'h00},
		'{8'hff, 1'b1, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'h55, 1'b0, 1'b0, 8'h00},
		'{8'haa, 1'b0, 1'b0, 8'h00},
		'{8'h55, 1'b0, 1'b0, 8'h00},
		'{8'haa, 1'b0, 1'b0, 8'h00},
		'{8'h55, 1'b0, 1'b0, 8'h00},
		'{8'hff, 1'b1, 1'b0, 8'h00}
	};

	initial begin
		int unsigned sizes[] = '{2, 8, 0, 15, 3, 5, 4, 7, 6};
		int base;
		pix.valid = 1'b0;
		pix.pixel_index = '0;
		pix.last_pixel = 1'b0;
		mcs_reg = MCS_RESET;
		image_abandon();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		apb_read_check(MCS_RESET);

		// directed table
		foreach (dir_tab[i]) begin
			send_pixel(dir_tab[i].pix, dir_tab[i].last);
			if (dir_tab[i].chk && step_b0 !== dir_tab[i].b0)
				report_mismatch("directed table", step_b0, dir_tab[i].b0);
		end
		drain();

		// register sweep, including out-of-range values and both extremes
		foreach (sizes[s]) begin
			apb_write(sizes[s][3:0]);
			apb_read_check(sizes[s][3:0]);
			send_pixel(8'hff, 1'b1);                // single pixel, masked
			send_image(6, 4);
			drain();
		end

		// back-pressure: receiver holds off long while pixels keep coming
		apb_write(4'd8);
		fork
			begin
				hold_rx = 1'b1;
				repeat (400) @(negedge clk);
				hold_rx = 1'b0;
			end
			send_image(60, 3);
		join
		drain();

		// abandon an image mid-stream with a register write
		send_image(5, 4);
		send_pixel(8'h01, 1'b0);
		drain();
		apb_write(4'd2);

		// back-to-back pixels with the receiver always ready
		rx_noise = 1'b0;
		for (int unsigned k = 0; k < 40; k++)
			send_pixel(8'($urandom), k == 39, 1'b1);
		rx_noise = 1'b1;
		drain();

		// random images at random code sizes
		base = pix_sent;
		for (int r = 0; r < 6; r++) begin
			apb_write(4'($urandom_range(2, 8)));
			while (pix_sent < base + 35 * (r + 1))
				send_image($urandom_range(1, 25), $urandom_range(2, 6));
			drain();
		end

		$display("covered %0d pixels in %0d images, %0d bytes checked, sizes 2..8",
			pix_sent, images_done, bytes_seen);
		$display("including out-of-range sizes, mid-image abandon, long output stall");
		if (err_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
